/* src/nearest_palette_color_mapper_core_defines.svh */
// assertion macros for the palette mapper rtl
// no dependencies; included by the top level, which carries the concurrent checks
`ifndef NEAREST_PALETTE_COLOR_MAPPER_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NPCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define NPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/npcm_pkg.sv */
// shared types, constants and helpers for the palette mapper
// no dependencies; imported by every module of the block
package npcm_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int COUNT_W       = 9;
    localparam int COMP_W        = 8;
    localparam int INDEX_W       = 8;
    localparam int SQ_W          = 2 * COMP_W;
    localparam int DIST_W        = SQ_W + 2;

    localparam logic [DIST_W-1:0] DIST_INF = '1;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               command;
        logic [INDEX_W-1:0] entry_index;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
    } request_t;

    typedef struct packed
    {
        logic [COMP_W-1:0]  out_red;
        logic [COMP_W-1:0]  out_green;
        logic [COMP_W-1:0]  out_blue;
        logic [INDEX_W-1:0] chosen_index;
    } result_t;

    typedef struct packed
    {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } color_t;

    // item as it moves down the cell chain, with the running best match
    typedef struct packed
    {
        cmd_t               command;
        logic [INDEX_W-1:0] entry_index;
        color_t             pixel;
        logic [DIST_W-1:0]  best_dist;
        logic [INDEX_W-1:0] best_index;
        color_t             best_color;
    } chain_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return SQ_W'(d) * SQ_W'(d);
        end
    endfunction

endpackage

/* src/npcm_cell.sv */
// one palette cell: holds one entry, takes entry writes, updates the best match
// depends on npcm_pkg
module npcm_cell
    import npcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [CNT_W-1:0]   cell_index,
    input  logic [COUNT_W-1:0] palette_entries,
    input  logic               prev_valid,
    input  chain_t             prev_data,
    output logic               next_valid,
    output chain_t             next_data
);

    color_t            entry_reg;
    color_t            entry_next;
    logic              valid_reg;
    logic              valid_next;
    chain_t            data_reg;
    chain_t            data_next;
    logic              active;
    logic              is_first;
    logic              closer;
    logic              write_hit;
    logic [DIST_W-1:0] entry_dist;

    always_comb
    begin
        active     = 32'(cell_index) < 32'(palette_entries);
        is_first   = (cell_index == '0);
        entry_dist = DIST_W'(sq_diff(prev_data.pixel.red, entry_reg.red))
                   + DIST_W'(sq_diff(prev_data.pixel.green, entry_reg.green))
                   + DIST_W'(sq_diff(prev_data.pixel.blue, entry_reg.blue));
        // strict compare keeps the lowest index on ties
        closer     = active && (entry_dist < prev_data.best_dist);
        write_hit  = prev_valid && (prev_data.command == CMD_WRITE)
                   && (32'(prev_data.entry_index) == 32'(cell_index));

        entry_next = write_hit ? prev_data.pixel : entry_reg;
        valid_next = prev_valid;
        data_next  = prev_data;
        if (prev_data.command == CMD_PIXEL)
        begin
            // first cell seeds the search, so an empty palette yields entry 0
            if (is_first)
            begin
                data_next.best_color = entry_reg;
                data_next.best_index = INDEX_W'(cell_index);
                data_next.best_dist  = active ? entry_dist : DIST_INF;
            end
            else if (closer)
            begin
                data_next.best_color = entry_reg;
                data_next.best_index = INDEX_W'(cell_index);
                data_next.best_dist  = entry_dist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            entry_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign next_valid = valid_reg;
    assign next_data  = data_reg;

endmodule

/* src/npcm_out.sv */
// result register at the end of the cell chain, drives the chain advance
// depends on npcm_pkg
module npcm_out
    import npcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tail_valid,
    input  chain_t  tail_data,
    input  logic    result_stall,
    output logic    advance,
    output logic    result_valid,
    output result_t result
);

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        advance           = !result_valid_reg || !result_stall;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (advance)
        begin
            // entry writes leave the chain without a result
            result_valid_next        = tail_valid && (tail_data.command == CMD_PIXEL);
            result_next.out_red      = tail_data.best_color.red;
            result_next.out_green    = tail_data.best_color.green;
            result_next.out_blue     = tail_data.best_color.blue;
            result_next.chosen_index = tail_data.best_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* src/nearest_palette_color_mapper_core.sv */
// top level of the nearest palette color mapper
// depends on npcm_pkg, npcm_cell, npcm_out and the assertion macro header
//
// usage
//   request channel (request_valid / request_stall / request): one transfer is
//   either an entry write (command CMD_WRITE, entry_index plus color) or a
//   pixel (command CMD_PIXEL, color). result channel (result_valid /
//   result_stall / result): one transfer per pixel with the nearest entry's
//   color and index, lowest index on equal distance. writes give no result
//   cfg_we / cfg_wdata set the number of entries searched; write it only while
//   nothing is in flight. zero entries maps every pixel to entry 0
//   a request reaches result valid through the chain of PALETTE_DEPTH
//   cells and then the result register
//   throughput: one transfer per cycle while the chain advances; every cell
//   holds one entry and hands the item and its running best match to its
//   neighbor; entry writes ride the chain too, so they stay ordered against pixels
//   reset: entry count goes to zero, all entries to black, chain empties
//   a stalled full result register freezes the whole chain and raises
//   request_stall in the same cycle; nothing is dropped
`include "nearest_palette_color_mapper_core_defines.svh"

module nearest_palette_color_mapper_core
    import npcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  request_t           request,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    logic [COUNT_W-1:0] entries_reg;
    logic [COUNT_W-1:0] entries_next;
    logic               advance;

    // stage i feeds cell i; the last stage feeds the result register
    logic               stage_valid [PALETTE_DEPTH+1];
    chain_t             stage_data  [PALETTE_DEPTH+1];

    // config register
    always_comb
    begin
        entries_next = cfg_we ? cfg_wdata : entries_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    // chain head: a request transfer happens exactly when the chain moves
    always_comb
    begin
        request_stall                  = !advance;
        stage_valid[0]                 = request_valid;
        stage_data[0].command          = request.command;
        stage_data[0].entry_index      = request.entry_index;
        stage_data[0].pixel.red        = request.red;
        stage_data[0].pixel.green      = request.green;
        stage_data[0].pixel.blue       = request.blue;
        stage_data[0].best_dist        = DIST_INF;
        stage_data[0].best_index       = '0;
        stage_data[0].best_color       = '0;
    end

    // row of palette cells
    for (genvar i = 0; i < PALETTE_DEPTH; i++)
    begin : g_cell
        npcm_cell u_cell
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (advance),
            .cell_index      (CNT_W'(i)),
            .palette_entries (entries_reg),
            .prev_valid      (stage_valid[i]),
            .prev_data       (stage_data[i]),
            .next_valid      (stage_valid[i+1]),
            .next_data       (stage_data[i+1])
        );
    end

    // result register and chain flow control
    npcm_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tail_valid   (stage_valid[PALETTE_DEPTH]),
        .tail_data    (stage_data[PALETTE_DEPTH]),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result)
    );

    // a held result must back-pressure the request side
    `NPCM_ASSERT_IMP(a_backpressure, clk, rst_n, result_valid && result_stall, request_stall)
    // an accepted request occupies the first cell stage next cycle
    `NPCM_ASSERT_NEXT(a_enter_chain, clk, rst_n, request_valid && !request_stall, stage_valid[1])
    // with no entries in use, every pixel maps to entry 0
    `NPCM_ASSERT_IMP(a_empty_first, clk, rst_n, result_valid && (entries_reg == '0), result.chosen_index == '0)

endmodule
